// File: rtl/vn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// shared widths, constants and types of the 3d vector normaliser
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int LANES       = 3;
    localparam int FRAC_UNIT   = 14;
    localparam int OUT_W       = 16;
    localparam int SUM_W       = 2 * COORD_WIDTH;
    localparam int RAD_W       = SUM_W + 16;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int Q_W         = 16;
    localparam int NUM_W       = COORD_WIDTH + 22 + 1;
    localparam int S_TDATA_W   = ((LANES * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = 4 * OUT_W;

    localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(1) << FRAC_UNIT;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] mag;
        logic                   neg;
    } lane_t;

endpackage

// File: rtl/vn_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module vn_sqrt (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [vn_pkg::RAD_W-1:0]  rad,
    output logic [vn_pkg::ROOT_W-1:0] root
);
    import vn_pkg::*;

    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_next [ROOT_W];
    logic [REM_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] root_next[ROOT_W];

    always_comb begin
        logic [RAD_W-1:0]  rad_p;
        logic [REM_W-1:0]  rem_p;
        logic [ROOT_W-1:0] root_p;
        logic [REM_W-1:0]  rem2;
        logic [REM_W-1:0]  trial;
        for (int k = 0; k < ROOT_W; k++) begin
            rad_p  = (k == 0) ? rad : rad_reg[k > 0 ? k - 1 : 0];
            rem_p  = (k == 0) ? '0  : rem_reg[k > 0 ? k - 1 : 0];
            root_p = (k == 0) ? '0  : root_reg[k > 0 ? k - 1 : 0];
            // bring down the next pair of radicand bits
            rem2   = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
            trial  = {root_p, 2'b01};
            rad_next[k] = {rad_p[RAD_W-3:0], 2'b00};
            if (rem2 >= trial) begin
                rem_next[k]  = rem2 - trial;
                root_next[k] = {root_p[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem2;
                root_next[k] = {root_p[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

// File: rtl/vn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_div
// one lane: rounded quotient of magnitude * 2^22 over the fine length
// ----------------------------------------------------------------------------
module vn_div (
    input  logic                      aclk,
    input  logic                      en,
    input  vn_pkg::lane_t             lane_in,
    input  logic [vn_pkg::ROOT_W-1:0] fine,
    output logic [vn_pkg::Q_W-1:0]    quot,
    output logic                      neg,
    output logic [vn_pkg::ROOT_W-1:0] fine_out
);
    import vn_pkg::*;

    logic [NUM_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [ROOT_W-1:0] fine_reg [Q_W];
    logic              neg_reg  [Q_W];
    logic [NUM_W-1:0]  rem_next [Q_W];
    logic [Q_W-1:0]    q_next   [Q_W];
    logic [NUM_W-1:0]  num;

    // rounding: add half the divisor before the restoring division
    assign num = (NUM_W'(lane_in.mag) << 22) + NUM_W'(fine >> 1);

    always_comb begin
        logic [NUM_W-1:0]  rem_p;
        logic [Q_W-1:0]    q_p;
        logic [ROOT_W-1:0] fine_p;
        logic [NUM_W-1:0]  dsor;
        for (int k = 0; k < Q_W; k++) begin
            rem_p  = (k == 0) ? num  : rem_reg[k > 0 ? k - 1 : 0];
            q_p    = (k == 0) ? '0   : q_reg[k > 0 ? k - 1 : 0];
            fine_p = (k == 0) ? fine : fine_reg[k > 0 ? k - 1 : 0];
            dsor   = NUM_W'(fine_p) << (Q_W - 1 - k);
            if (rem_p >= dsor) begin
                rem_next[k] = rem_p - dsor;
                q_next[k]   = q_p | (Q_W'(1) << (Q_W - 1 - k));
            end else begin
                rem_next[k] = rem_p;
                q_next[k]   = q_p;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < Q_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                fine_reg[k] <= (k == 0) ? fine : fine_reg[k > 0 ? k - 1 : 0];
                neg_reg[k]  <= (k == 0) ? lane_in.neg : neg_reg[k > 0 ? k - 1 : 0];
            end
        end
    end

    assign quot     = q_reg[Q_W-1];
    assign neg      = neg_reg[Q_W-1];
    assign fine_out = fine_reg[Q_W-1];

endmodule

// File: rtl/vector3_normalise.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalise
// length and unit vector of one signed fixed-point 3d vector per item
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output is not stalled, set by the bit-per-stage root and divider pipes
// the whole pipe holds while a result waits and the output is not taken
// reset (synchronous, active low) clears the valid bits only
module vector3_normalise (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vn_pkg::S_TDATA_W-1:0]  s_tdata,  // coord_x, coord_y, coord_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vn_pkg::M_TDATA_W-1:0]  m_tdata,  // unit_x, unit_y, unit_z, length
    output logic                          m_tuser   // zero_length
);
    import vn_pkg::*;

    localparam int LAT = 3 + ROOT_W + Q_W;

    logic                   en;
    logic [LAT-1:0]         vld_reg;
    lane_t                  lane_a_reg [LANES];
    lane_t                  lane_b_reg [LANES];
    lane_t                  lane_c_reg [LANES];
    lane_t                  lane_d_reg [LANES][ROOT_W];
    logic [SUM_W-1:0]       sq_b_reg   [LANES];
    logic [SUM_W-1:0]       sum_c_reg;
    logic [ROOT_W-1:0]      root;
    logic [Q_W-1:0]         quot       [LANES];
    logic                   qneg       [LANES];
    logic [ROOT_W-1:0]      fine_out   [LANES];
    logic [OUT_W-1:0]       unit_next  [LANES];
    logic [OUT_W-1:0]       len_next;
    logic                   zero_next;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic                   m_tuser_reg;

    assign en       = !(m_tvalid_reg && !m_tready);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                logic [COORD_WIDTH-1:0] c;
                c = s_tdata[l*COORD_WIDTH +: COORD_WIDTH];
                lane_a_reg[l].neg <= c[COORD_WIDTH-1];
                lane_a_reg[l].mag <= c[COORD_WIDTH-1] ? (~c + 1'b1) : c;
                lane_b_reg[l]     <= lane_a_reg[l];
                sq_b_reg[l]       <= SUM_W'(lane_a_reg[l].mag) * SUM_W'(lane_a_reg[l].mag);
                lane_c_reg[l]     <= lane_b_reg[l];
                // align the lanes with the root pipe
                for (int k = 0; k < ROOT_W; k++) begin
                    lane_d_reg[l][k] <= (k == 0) ? lane_c_reg[l]
                                                 : lane_d_reg[l][k > 0 ? k - 1 : 0];
                end
            end
            sum_c_reg <= sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];
        end
    end

    vn_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  ({sum_c_reg, 16'h0000}),
        .root (root)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        vn_div u_div (
            .aclk     (aclk),
            .en       (en),
            .lane_in  (lane_d_reg[l][ROOT_W-1]),
            .fine     (root),
            .quot     (quot[l]),
            .neg      (qneg[l]),
            .fine_out (fine_out[l])
        );
    end

    // merge: cap, sign, length and the zero vector case
    always_comb begin
        logic [Q_W-1:0]      q;
        logic [ROOT_W-9:0]   len_full;
        zero_next = (fine_out[0] == '0);
        for (int l = 0; l < LANES; l++) begin
            q = (quot[l] > UNIT_ONE) ? UNIT_ONE : quot[l];
            if (zero_next) begin
                unit_next[l] = '0;
            end else if (qneg[l]) begin
                unit_next[l] = OUT_W'(~q + 1'b1);
            end else begin
                unit_next[l] = OUT_W'(q);
            end
        end
        len_full = fine_out[0][ROOT_W-1:8];
        if (ROOT_W - 8 > OUT_W && (len_full >> OUT_W) != '0) begin
            len_next = '1;
        end else begin
            len_next = OUT_W'(len_full);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {len_next, unit_next[2], unit_next[1], unit_next[0]};
            m_tuser_reg <= zero_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_zero_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero vector result carries non-zero data");

    a_len_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[4*OUT_W-1:3*OUT_W] != '0)
        else $error("non-zero vector with zero length");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
`endif

endmodule
